[src/svflc_pkg.sv]
// Shared types and constants of the state-variable filter with limit-cycle breaker.
// Holds field widths, register codes, controller states and the history ring command set.
// No dependencies.
`default_nettype none

package svflc_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W    = 11;
  localparam int unsigned OUT_W       = 19;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CUTOFF_W    = 14;
  localparam int unsigned DAMP_W      = 15;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned FRAC_BITS   = 14;

  // Register reset values
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(1155);
  localparam logic [DAMP_W-1:0]   DAMP_RESET   = DAMP_W'(23174);
  localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_W'(1);

  // Mode mask bit positions
  localparam int unsigned MODE_LP_BIT = 0;
  localparam int unsigned MODE_BP_BIT = 1;
  localparam int unsigned MODE_HP_BIT = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF  = 2'd0,
    REG_DAMPING = 2'd1,
    REG_MODE    = 2'd2
  } cfg_reg_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAMP,
    ST_HP,
    ST_FHP,
    ST_BP,
    ST_FBP,
    ST_LP,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // History ring commands
  typedef enum logic [2:0] {
    RING_IDLE,
    RING_START,
    RING_SCAN,
    RING_INSERT,
    RING_CLEAR
  } ring_cmd_e;

  // History ring status back to the controller
  typedef struct packed {
    logic last_step;
    logic hit;
  } ring_status_t;

endpackage

`default_nettype wire

[src/svflc_cell.sv]
// One history cell: stores a single (low, band) pair and passes it on when shifted.
// Depends on nothing but its parameters.
`default_nettype none

module svflc_cell #(
  parameter int unsigned LOW_W  = 19,
  parameter int unsigned BAND_W = 19
) (
  input  wire logic              clk_i,
  input  wire logic              shift_i,
  input  wire logic [LOW_W-1:0]  low_i,
  input  wire logic [BAND_W-1:0] band_i,
  output logic      [LOW_W-1:0]  low_o,
  output logic      [BAND_W-1:0] band_o
);

  logic [LOW_W-1:0]  low_q;
  logic [BAND_W-1:0] band_q;

  // Take the neighbor's pair on a shift, hold otherwise
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      low_q  <= low_i;
      band_q <= band_i;
    end
  end

  assign low_o  = low_q;
  assign band_o = band_q;

endmodule

`default_nettype wire

[src/svflc_ring.sv]
// History ring: a circular chain of svflc_cell with a fill count and a compare at the tail.
// A scan rotates the chain once around; an insert shifts a new pair in at the head.
// Depends on svflc_pkg and svflc_cell.
`default_nettype none

module svflc_ring import svflc_pkg::*; #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned LOW_W  = 19,
  parameter int unsigned BAND_W = 19
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ring_cmd_e         cmd_i,
  input  wire logic [LOW_W-1:0]  key_low_i,
  input  wire logic [BAND_W-1:0] key_band_i,
  output ring_status_t           status_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned STP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = CNT_W + 1;

  logic [LOW_W-1:0]  low_chain  [DEPTH];
  logic [BAND_W-1:0] band_chain [DEPTH];
  logic [LOW_W-1:0]  head_low;
  logic [BAND_W-1:0] head_band;
  logic              shift;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STP_W-1:0]  step_q, step_d;
  logic              hit_q, hit_d;
  logic              tail_valid;
  logic              tail_match;

  // Feed the head from the key on insert, from the tail on rotate
  assign shift     = (cmd_i == RING_SCAN) || (cmd_i == RING_INSERT);
  assign head_low  = (cmd_i == RING_INSERT) ? key_low_i  : low_chain[DEPTH-1];
  assign head_band = (cmd_i == RING_INSERT) ? key_band_i : band_chain[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      svflc_cell #(.LOW_W(LOW_W), .BAND_W(BAND_W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .low_i  (head_low),
        .band_i (head_band),
        .low_o  (low_chain[i]),
        .band_o (band_chain[i])
      );
    end else begin : g_body
      svflc_cell #(.LOW_W(LOW_W), .BAND_W(BAND_W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .low_i  (low_chain[i-1]),
        .band_i (band_chain[i-1]),
        .low_o  (low_chain[i]),
        .band_o (band_chain[i])
      );
    end
  end

  // At scan step s the tail holds entry DEPTH-1-s, stored when s + count >= DEPTH
  assign tail_valid = (CMP_W'(step_q) + CMP_W'(count_q)) >= CMP_W'(DEPTH);
  assign tail_match = tail_valid && (low_chain[DEPTH-1] == key_low_i) &&
                      (band_chain[DEPTH-1] == key_band_i);

  // Advance the step counter, hit flag and fill count
  always_comb begin
    count_d = count_q;
    step_d  = step_q;
    hit_d   = hit_q;
    unique case (cmd_i)
      RING_START: begin
        step_d = '0;
        hit_d  = 1'b0;
      end
      RING_SCAN: begin
        step_d = step_q + STP_W'(1);
        hit_d  = hit_q | tail_match;
      end
      RING_INSERT: begin
        if (count_q != CNT_W'(DEPTH)) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      RING_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      step_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      step_q  <= step_d;
      hit_q   <= hit_d;
    end
  end

  assign status_o.last_step = (step_q == STP_W'(DEPTH - 1));
  assign status_o.hit       = hit_q;

endmodule

`default_nettype wire

[src/state_variable_filter_limit_cycle.sv]
// State-variable filter (Q14) with limit-cycle breaker on silent input: top level.
// Holds the controller, the shared multiplier, the filter states and the output register.
// Depends on svflc_pkg and svflc_ring (which uses svflc_cell).
//
// Usage:
//   Samples arrive on the s_axis request channel (11-bit signed in tdata[10:0]); each
//   gives one filtered sample on the m_axis channel (19-bit signed in tdata[18:0]).
//   Coefficients and the tap mask are written on cfg_we_i/cfg_index_i/cfg_data_i
//   while no sample is in flight; index 3 is ignored.
//   Sequencing: the three dependent products share one multiplier, so the filter math
//   steps through the states DAMP, HP, FHP, BP, FBP and LP in turn. A nonzero sample
//   then passes UPDATE and OUT before the controller returns to idle.
//   A zero sample rotates the history chain once around in the SCAN state, to
//   compare the new state pair against every stored pair, then goes through DECIDE.
//   One sample is in work at a time; s_axis_tready is high only while idle.
//   The result sits in an output register, so a new sample may be taken while it
//   waits; if the receiver still stalls when the next result is ready, the
//   controller holds until the register frees.
//   Reset clears the filter states, the history fill count and the coefficients
//   to their defaults; the history cells themselves are not cleared.
`default_nettype none

module state_variable_filter_limit_cycle import svflc_pkg::*; #(
  parameter int unsigned HISTORY_LEN = 512,
  parameter int unsigned STATE_MAX   = 32767
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input request channel
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [10:0] sample_in
  // Output request channel
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [18:0] sample_out
  // Configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // State and intermediate widths follow from the saturation bound S:
  // |hp| <= 3S+1025, |band'| <= 4S+1025, |low'| <= 5S+1025
  localparam int unsigned SW    = $clog2(STATE_MAX + 1) + 1;
  localparam int unsigned HP_W  = $clog2(3 * STATE_MAX + 1026) + 1;
  localparam int unsigned BP_W  = $clog2(4 * STATE_MAX + 1026) + 1;
  localparam int unsigned LP_W  = $clog2(5 * STATE_MAX + 1026) + 1;
  localparam int unsigned PRD_W = DAMP_W + 1 + BP_W;
  localparam int unsigned SUM_W = (HP_W + 2 > OUT_W) ? HP_W + 2 : OUT_W;

  localparam logic signed [LP_W-1:0] SAT_HI   = LP_W'(STATE_MAX);
  localparam logic signed [LP_W-1:0] SAT_LO   = -SAT_HI;
  localparam logic signed [SW-1:0]   STATE_HI = SW'(STATE_MAX);

  state_e state_q, state_d;

  logic [CUTOFF_W-1:0] cutoff_q;
  logic [DAMP_W-1:0]   damp_q;
  logic [MODE_W-1:0]   mode_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SW-1:0]       low_q, band_q;
  logic signed [HP_W-1:0]     hp_q;
  logic signed [BP_W-1:0]     bp_q;
  logic signed [LP_W-1:0]     lp_q;
  logic signed [PRD_W-1:0]    prod_q, prod_d;
  logic signed [PRD_W-1:0]    prod_shr;

  logic [DAMP_W-1:0]       mul_a;
  logic signed [BP_W-1:0]  mul_b;
  logic signed [SUM_W-1:0] sum;
  logic signed [OUT_W-1:0] out_q;
  logic                    out_valid_q;
  logic                    in_accept;
  logic                    out_free;

  ring_cmd_e    ring_cmd;
  ring_status_t ring_status;

  function automatic logic signed [SW-1:0] saturate(input logic signed [LP_W-1:0] v);
    logic signed [LP_W-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[SW-1:0];
  endfunction

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
      damp_q   <= DAMP_RESET;
      mode_q   <= MODE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CUTOFF:  cutoff_q <= cfg_data_i[CUTOFF_W-1:0];
        REG_DAMPING: damp_q   <= cfg_data_i[DAMP_W-1:0];
        REG_MODE:    mode_q   <= cfg_data_i[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Next state and ring command
  always_comb begin
    state_d  = state_q;
    ring_cmd = RING_IDLE;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_DAMP;
      ST_DAMP:   state_d = ST_HP;
      ST_HP:     state_d = ST_FHP;
      ST_FHP:    state_d = ST_BP;
      ST_BP:     state_d = ST_FBP;
      ST_FBP:    state_d = ST_LP;
      ST_LP: begin
        if (x_q == '0) begin
          ring_cmd = RING_START;
          state_d  = ST_SCAN;
        end else begin
          ring_cmd = RING_CLEAR;
          state_d  = ST_UPDATE;
        end
      end
      ST_SCAN: begin
        ring_cmd = RING_SCAN;
        if (ring_status.last_step) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        ring_cmd = ring_status.hit ? RING_CLEAR : RING_INSERT;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared multiplier: damping * band, then cutoff * hp, then cutoff * band'
  always_comb begin
    mul_a = {1'b0, cutoff_q};
    mul_b = bp_q;
    unique case (state_q)
      ST_DAMP: begin
        mul_a = damp_q;
        mul_b = BP_W'(band_q);
      end
      ST_FHP: mul_b = BP_W'(hp_q);
      default: begin
      end
    endcase
  end

  assign prod_d   = $signed({1'b0, mul_a}) * mul_b;
  assign prod_shr = prod_q >>> FRAC_BITS;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:   if (in_accept) x_q <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
      ST_DAMP:   prod_q <= prod_d;
      ST_HP:     hp_q <= HP_W'(x_q) - HP_W'(low_q) - HP_W'(prod_shr);
      ST_FHP:    prod_q <= prod_d;
      ST_BP:     bp_q <= BP_W'(band_q) + BP_W'(prod_shr);
      ST_FBP:    prod_q <= prod_d;
      ST_LP:     lp_q <= LP_W'(low_q) + LP_W'(prod_shr);
      ST_DECIDE: begin
        if (ring_status.hit) begin
          lp_q <= '0;
          bp_q <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Filter states: saturate the new pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      band_q <= '0;
    end else if (state_q == ST_UPDATE) begin
      low_q  <= saturate(lp_q);
      band_q <= saturate(LP_W'(bp_q));
    end
  end

  // Sum the selected taps
  always_comb begin
    sum = '0;
    if (mode_q[MODE_LP_BIT]) sum = sum + SUM_W'(low_q);
    if (mode_q[MODE_BP_BIT]) sum = sum + SUM_W'(band_q);
    if (mode_q[MODE_HP_BIT]) sum = sum + SUM_W'(hp_q);
  end

  // Output register: load when free, drop the request when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_q <= sum[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_q};

  svflc_ring #(
    .DEPTH (HISTORY_LEN),
    .LOW_W (LP_W),
    .BAND_W(BP_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .key_low_i (lp_q),
    .key_band_i(bp_q),
    .status_o  (ring_status)
  );

  // An accepted sample starts the multiply sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_DAMP)
    else $error("accepted sample did not start the filter sequence");

  // Saturated states stay within the bound
  a_state_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q <= STATE_HI) && (low_q >= -STATE_HI) &&
    (band_q <= STATE_HI) && (band_q >= -STATE_HI))
    else $error("filter state outside saturation bound");

  // History is scanned only for silent samples
  a_scan_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (x_q == '0))
    else $error("history scan on a nonzero sample");

  // A pending result is not overwritten while the receiver stalls
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_OUT))
    else $error("result left while output register still full");

endmodule

`default_nettype wire
